### hdl/fcr_pkg.sv
// Shared types and constants for the feedback comb reverb.
// Holds the configuration register map and fixed field widths; no dependencies.
package fcr_pkg;

  localparam int DELAY_REG_W = 13;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [DELAY_REG_W-1:0] delay_t;
  typedef logic [GAIN_W-1:0]      gain_t;

  localparam cfg_idx_t CFG_DELAY_SAMPLES = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_FEEDBACK_GAIN = cfg_idx_t'(1);

endpackage

### hdl/feedback_comb_reverb.sv
// Feedback comb reverb top level: echo memory, read-modify-write pipeline, output register.
// Depends on fcr_pkg.
//
// The block takes one item per clock cycle, sustained while the output is not stalled. Each item
// passes through the read stage and then the output register. The echo memory read is issued
// at the accepting edge; the multiply, round, add and saturate land in the output register when
// the item leaves the read stage. The rate is set by the feedback loop: with a delay of one
// sample, each result depends on the one just computed, so that value is forwarded from the
// write side into the next computation, and the memory needs only one read and one write port
// per cycle. Input stall is raised only while a finished result waits in the output register
// and the next item is ready behind it. The echo memory is not cleared after reset: within a
// clip, an entry is read only after it has been written.
module feedback_comb_reverb #(
  parameter int DELAY_MAX   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          in_last_in_clip,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_last_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  fcr_pkg::cfg_idx_t             cfg_index,
  input  logic [fcr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fcr_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int AW = (DELAY_MAX > 1) ? $clog2(DELAY_MAX) : 1;
  localparam int CW = $clog2(DELAY_MAX + 1);
  localparam int PW = SB + GAIN_W + 1;
  localparam int FW = PW - GAIN_FRAC;
  localparam int SW = SB + 4;
  localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (SB - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
  localparam logic signed [PW-1:0] ROUND_BIAS = PW'(1) <<< (GAIN_FRAC - 1);

  // Configuration registers.
  delay_t delay_r;
  gain_t  gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= delay_t'(1);
      gain_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELAY_SAMPLES: delay_r <= cfg_data[DELAY_REG_W-1:0];
        CFG_FEEDBACK_GAIN: gain_r  <= cfg_data[GAIN_W-1:0];
        default:           ;
      endcase
    end
  end

  // Pipeline control.
  logic a_valid_r;
  logic a_move;
  logic in_acc;
  logic out_valid_r;

  assign a_move   = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && !a_move;
  assign in_acc   = in_valid && !in_stall;

  // Effective delay, clamped into 1..DELAY_MAX.
  logic [31:0]   d_wide;
  logic [CW-1:0] d_eff;

  always_comb begin
    d_wide = 32'(delay_r);
    if (d_wide == 32'd0) begin
      d_wide = 32'd1;
    end else if (d_wide > 32'(DELAY_MAX)) begin
      d_wide = 32'(DELAY_MAX);
    end
    d_eff = d_wide[CW-1:0];
  end

  // Write pointer and clip position.
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] clip_r, clip_nxt;
  logic [31:0]   rd_wide;
  logic [AW-1:0] rd_addr;
  logic          use_fb;

  always_comb begin
    if (32'(wp_r) >= 32'(d_eff)) begin
      rd_wide = 32'(wp_r) - 32'(d_eff);
    end else begin
      rd_wide = 32'(wp_r) + 32'(DELAY_MAX) - 32'(d_eff);
    end
    rd_addr = rd_wide[AW-1:0];
    use_fb  = (clip_r >= d_eff);

    wp_nxt = (32'(wp_r) == 32'(DELAY_MAX - 1)) ? '0 : wp_r + AW'(1);

    if (in_last_in_clip) begin
      clip_nxt = '0;
    end else if (32'(clip_r) < 32'(DELAY_MAX)) begin
      clip_nxt = clip_r + CW'(1);
    end else begin
      clip_nxt = clip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      clip_r <= '0;
    end else if (in_acc) begin
      wp_r   <= wp_nxt;
      clip_r <= clip_nxt;
    end
  end

  // Read stage: item waits here while the memory read completes.
  logic signed [SB-1:0] a_x_r;
  logic                 a_last_r;
  logic                 a_fb_r;
  logic                 a_fwd_r;
  logic [AW-1:0]        a_wp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  // When the item leaving at the same edge writes the entry this one reads, its
  // value is taken from the forwarding register instead of the stale memory word.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_x_r    <= in_sample_in;
      a_last_r <= in_last_in_clip;
      a_fb_r   <= use_fb;
      a_fwd_r  <= a_move && (a_wp_r == rd_addr);
      a_wp_r   <= wp_r;
    end
  end

  // Echo memory: one read port, one write port.
  logic signed [SB-1:0] echo_mem [DELAY_MAX];
  logic signed [SB-1:0] rdata_r;
  logic signed [SB-1:0] fwd_y_r;
  logic signed [SB-1:0] y;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rdata_r <= echo_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      echo_mem[a_wp_r] <= y;
      fwd_y_r          <= y;
    end
  end

  // Multiply, round to nearest with ties upward, add and saturate; before the echo is due, the sample passes through.
  logic signed [SB-1:0] past;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_rnd;
  logic signed [FW-1:0] fb;
  logic signed [SW-1:0] sum;

  always_comb begin
    past     = a_fwd_r ? fwd_y_r : rdata_r;
    prod     = PW'(past) * PW'(signed'({1'b0, gain_r}));
    prod_rnd = (prod + ROUND_BIAS) >>> GAIN_FRAC;
    fb       = prod_rnd[FW-1:0];
    sum      = SW'(a_x_r) + SW'(fb);
    if (!a_fb_r) begin
      y = a_x_r;
    end else if (sum > SMAX) begin
      y = SMAX[SB-1:0];
    end else if (sum < SMIN) begin
      y = SMIN[SB-1:0];
    end else begin
      y = sum[SB-1:0];
    end
  end

  // Output register.
  logic signed [SB-1:0] out_sample_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_sample_r <= y;
      out_last_r   <= a_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_last_out   = out_last_r;

endmodule

### hdl/fcr_checker.sv
// Port-level checks for the feedback comb reverb, with the bind that attaches them.
// Depends on fcr_pkg and on the feedback_comb_reverb port list.
module fcr_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input logic                          in_last_in_clip,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input logic                          out_last_out,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input fcr_pkg::cfg_idx_t             cfg_index,
  input logic [fcr_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The input side backs up only when a finished result is held downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output side can move");

  // A stalled result stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_sample_out) && $stable(out_last_out)))
    else $error("result payload changed while stalled");

endmodule

bind feedback_comb_reverb fcr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fcr_checker (.*);

### bench/feedback_comb_reverb_check.sv
// Result checker for the feedback comb reverb: follows the input, result and register channels.
// Predicts each result from its own echo line copy and compares field by field.
// Depends on fcr_pkg for the register map and field types.
module feedback_comb_reverb_check #(
  parameter int ECHO_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [15:0]             in_sample_in,
  input  logic                           in_last_in_clip,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [15:0]             out_sample_out,
  input  logic                           out_last_out,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  fcr_pkg::cfg_idx_t              cfg_index,
  input  logic [fcr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import fcr_pkg::*;

  localparam int PTR_W       = $clog2(ECHO_DEPTH);
  localparam longint SAT_HI  = 32767;
  localparam longint SAT_LO  = -32768;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } reverb_out_t;

  logic signed [15:0] echo_copy [ECHO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  int unsigned        clip_pos;
  delay_t             delay_reg;
  gain_t              gain_reg;
  reverb_out_t        expected_q [$];

  // Computes the next output sample and advances the echo line and clip count.
  function automatic reverb_out_t reverb_sample(input logic signed [15:0] x, input logic last);
    int unsigned      d;
    logic [PTR_W-1:0] rd;
    longint           acc;
    reverb_out_t      r;
    d = delay_reg;
    if (d == 0) d = 1;
    if (d > ECHO_DEPTH) d = ECHO_DEPTH;
    acc = x;
    if (clip_pos >= d) begin
      rd  = wr_ptr - PTR_W'(d);
      // Q.29 product rounded to Q.15; the arithmetic shift floors, so ties go up.
      acc = longint'(x) + ((longint'(echo_copy[rd]) * longint'(gain_reg)
            + longint'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC);
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
    end
    echo_copy[wr_ptr] = acc[15:0];
    wr_ptr = wr_ptr + 1'b1;
    if (last) clip_pos = 0;
    else if (clip_pos < ECHO_DEPTH) clip_pos++;
    r.sample = acc[15:0];
    r.last   = last;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic signed [15:0] want,
                               input logic signed [15:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    reverb_out_t want;
    if (!rst_n) begin
      wr_ptr    = '0;
      clip_pos  = 0;
      delay_reg = delay_t'(1);
      gain_reg  = '0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, sample %0d last %0b",
                   $time, out_sample_out, out_last_out);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (out_sample_out !== want.sample)
            note_mismatch("sample_out", want.sample, out_sample_out);
          if (out_last_out !== want.last)
            note_mismatch("last_out", want.last, out_last_out);
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(reverb_sample(in_sample_in, in_last_in_clip));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DELAY_SAMPLES: delay_reg = cfg_data[DELAY_REG_W-1:0];
          CFG_FEEDBACK_GAIN: gain_reg = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

### bench/feedback_comb_reverb_tb.sv
// Top of the feedback comb reverb testbench: clock, reset, stimulus, output stall and verdict.
// Depends on fcr_pkg, the feedback_comb_reverb RTL and feedback_comb_reverb_check.
module feedback_comb_reverb_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fcr_pkg::*;

  localparam int ECHO_DEPTH    = 4096;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 60;
  localparam int FINAL_DELAY   = 24;
  localparam int FINAL_CLIP    = 160;

  // Indexes that map to no register; writes to them must change nothing.
  localparam cfg_idx_t CFG_SPARE_LO = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_SPARE_HI = cfg_idx_t'(3);

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic signed [15:0]    in_sample_in;
  logic                  in_last_in_clip;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [15:0]    out_sample_out;
  logic                  out_last_out;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   mismatches;
  int   pending;
  int   checked;
  bit   idle_on;
  bit   long_hold_req;
  int   tx_calm;
  int   sent_count;
  int   clip_count;
  int   settings;

  feedback_comb_reverb #(
    .DELAY_MAX  (ECHO_DEPTH),
    .SAMPLE_BITS(16)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_last_in_clip(in_last_in_clip),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_last_out   (out_last_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  feedback_comb_reverb_check #(
    .ECHO_DEPTH(ECHO_DEPTH)
  ) u_reverb_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_last_in_clip(in_last_in_clip),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_last_out   (out_last_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .checked        (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_sample(input logic signed [15:0] s, input logic l);
    int unsigned gap;
    gap = 0;
    if (idle_on) begin
      if (tx_calm > 0) tx_calm--;
      else if ($urandom_range(0, 99) < 15) gap = $urandom_range(1, 16);
      else if ($urandom_range(0, 99) < 5) tx_calm = $urandom_range(20, 80);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_sample_in    <= s;
    in_last_in_clip <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (l) clip_count++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering items and waits until every result is back, so registers can change.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    if (r < 4) return 16'(int'($urandom_range(0, 512)) - 256);
    return 16'($urandom);
  endfunction

  // Mostly whole clips long enough to bring in the echo, with some that end early.
  task automatic send_clips(input int unsigned target, input int unsigned d_eff);
    int unsigned n;
    int unsigned len;
    n = 0;
    while (n < target) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1, 2:    len = $urandom_range(1, d_eff);
        default: len = $urandom_range(d_eff + 1, 2 * d_eff + 8);
      endcase
      for (int unsigned k = 0; k < len; k++) send_sample(pick_sample(), k == len - 1);
      n += len;
    end
    // Sometimes leave a clip open so the next delay setting lands mid-clip.
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 6)) send_sample(pick_sample(), 1'b0);
  endtask

  // Receiver: random stall bursts, calm stretches, and one long hold on request.
  initial begin : result_sink
    int unsigned burst;
    int unsigned calm;
    int unsigned hold;
    int unsigned r;
    out_stall = 1'b0;
    burst = 0;
    calm  = 0;
    hold  = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (calm > 0) begin
        calm--;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          burst = $urandom_range(1, 16) - 1;
          out_stall <= 1'b1;
        end else begin
          if (r < 20) calm = $urandom_range(20, 80);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned dly;
    int unsigned d_eff;
    logic [15:0] gain;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample_in    = '0;
    in_last_in_clip = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_DELAY_SAMPLES;
    cfg_data        = '0;
    idle_on         = 1'b0;
    long_hold_req   = 1'b0;
    tx_calm         = 0;
    sent_count      = 0;
    clip_count      = 0;
    settings        = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // One-sample delay at full gain drives the sum into the upper saturation limit.
    write_reg(CFG_DELAY_SAMPLES, 16'd1);
    write_reg(CFG_FEEDBACK_GAIN, 16'hFFFF);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b1);
    settle();

    // A zero delay acts as one; half gain on odd samples puts the rounding on exact ties.
    write_reg(CFG_DELAY_SAMPLES, 16'd0);
    write_reg(CFG_FEEDBACK_GAIN, 16'h2000);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);
    settle();

    // A delay beyond the echo line clamps to its depth, so these pass straight through.
    write_reg(CFG_DELAY_SAMPLES, 16'h1FFF);
    write_reg(CFG_FEEDBACK_GAIN, 16'h4000);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sd300, 1'b0);
    settle();

    // Shortening the delay inside an open clip takes effect on the next sample.
    write_reg(CFG_DELAY_SAMPLES, 16'hE002);
    send_sample(16'sd400, 1'b0);
    send_sample(16'sd500, 1'b1);
    settle();

    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    send_sample(16'sd7, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd5, 1'b1);
    settings = 5;

    idle_on = 1'b1;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case ($urandom_range(0, 5))
        0:       dly = $urandom_range(0, 1);
        1, 2:    dly = $urandom_range(2, 8);
        3, 4:    dly = $urandom_range(9, 40);
        default: dly = $urandom_range(41, 64);
      endcase
      d_eff = (dly == 0) ? 1 : dly;
      case ($urandom_range(0, 5))
        0:       gain = 16'h0000;
        1:       gain = 16'hFFFF;
        2:       gain = 16'h4000;
        3, 4:    gain = 16'($urandom_range(4096, 15000));
        default: gain = 16'($urandom);
      endcase
      // Bits above the delay field carry noise that the block must drop.
      write_reg(CFG_DELAY_SAMPLES, {3'($urandom), 13'(dly)});
      write_reg(CFG_FEEDBACK_GAIN, gain);
      settings++;
      if (p == 2) long_hold_req = 1'b1;
      send_clips(PHASE_ITEMS, d_eff);
    end

    // Last part at full rate with no idling on either side: one long clip with echo, then a short clip.
    idle_on = 1'b0;
    settle();
    write_reg(CFG_DELAY_SAMPLES, 16'(FINAL_DELAY));
    write_reg(CFG_FEEDBACK_GAIN, 16'($urandom_range(8192, 16000)));
    settings++;
    for (int k = 0; k < FINAL_CLIP; k++)
      send_sample(pick_sample(), k == FINAL_CLIP - 1);
    repeat (4) send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);
    settle();

    $display("Checked %0d results from %0d samples in %0d clips over %0d register settings,",
             checked, sent_count, clip_count, settings);
    $display("with random stalls on both sides, a %0d-cycle output hold and a full-rate finish.",
             LONG_HOLD);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/fcr_pkg.sv
hdl/feedback_comb_reverb.sv
hdl/fcr_checker.sv
bench/feedback_comb_reverb_check.sv
bench/feedback_comb_reverb_tb.sv
